[src/cfd_pkg.sv]
`timescale 1ns / 1ps

package cfd_pkg;

    // Window geometry: the last byte of a frame is compared straight off the
    // input, so the chain holds one byte less than a full frame.
    localparam int unsigned FRAME_LEN  = 16;
    localparam int unsigned CHAIN_LEN  = FRAME_LEN - 1;
    localparam int unsigned FILL_W     = 4;
    localparam int unsigned TAG_FIRST  = 12;
    localparam int unsigned OPCODE_POS = 6;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TAG     = 1'd1;
    localparam logic [31:0] FRAME_TAG_RESET = 32'h1234_5678;

    // Opcodes carried in frame byte 6
    localparam logic [7:0] OP_START  = 8'd8;
    localparam logic [7:0] OP_STOP   = 8'd6;
    localparam logic [7:0] OP_QUERY  = 8'd2;
    localparam logic [7:0] OP_PROMPT = 8'd11;

    // Fixed bytes 0..11 of a frame; the opcode position is never compared.
    localparam logic [7:0] FRAME_PAT [TAG_FIRST] = '{
        8'hA5, 8'hA5, 8'h5A, 8'h5A, 8'h00, 8'h00,
        8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01
    };

    typedef enum logic [2:0] {
        EVT_NONE   = 3'd0,
        EVT_START  = 3'd1,
        EVT_STOP   = 3'd2,
        EVT_QUERY  = 3'd3,
        EVT_PROMPT = 3'd4
    } t_event;

endpackage

[src/cfd_cell.sv]
`timescale 1ns / 1ps

module cfd_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_expect,
    output logic [7:0] o_byte,
    output logic       o_hit
);
    import cfd_pkg::*;

    logic [7:0] r_byte;

    // Advance one place toward the oldest end on every transfer.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = (r_byte == i_expect);

endmodule

[src/command_frame_detector.sv]
`timescale 1ns / 1ps

// Command frame detector. Each input transfer carries one received serial byte
// and its line-error flags; each one yields exactly one output transfer with a
// command event (none, start, stop, query or prompt). Any nonzero error flag
// empties the window. Error-free bytes shift into a chain of fifteen byte cells;
// once fifteen bytes are held, the cells plus the arriving byte form a 16-byte
// frame that is checked in the same cycle against A5 A5 5A 5A 00 00 op 01
// 00 00 00 01 and the frame tag (least significant byte first). A recognized
// opcode raises its event and empties the window; otherwise the window slides
// by one byte. Throughput is one byte per clock while the input is not stalled:
// the chain shifts and the compare result is registered in the output stage in
// the cycle of the transfer, so an item's event appears in the cycle after it is
// taken. Input is stalled only while the output register holds a result that is
// itself stalled. Configuration: index 0 enables opcode 11 as prompt (reset 0),
// index 1 sets the 32-bit frame tag (reset 0x12345678); write only while idle.

module command_frame_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic [3:0]                        i_line_error,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_command_event
);
    import cfd_pkg::*;

    logic                 r_prompt_en;
    logic [31:0]          r_tag;
    logic [FILL_W-1:0]    r_fill;
    logic [FILL_W-1:0]    n_fill;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_event               r_event;
    t_event               n_event;

    logic                 in_xfer;
    logic [7:0]           cell_byte   [CHAIN_LEN];
    logic [7:0]           cell_expect [CHAIN_LEN];
    logic [CHAIN_LEN-1:0] cell_hit;
    logic                 frame_hit;
    t_event               decoded;

    // Take a new byte whenever the output register is empty or being drained.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_xfer    = i_in_valid & ~o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prompt_en <= 1'b0;
            r_tag       <= FRAME_TAG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROMPT_ENABLE: r_prompt_en <= i_cfg_wdata[0];
                CFG_FRAME_TAG:     r_tag       <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Byte chain: cell 0 holds the oldest byte, the newest enters at the top.
    genvar k;
    generate
        for (k = 0; k < CHAIN_LEN; k++) begin : g_cell
            if (k < TAG_FIRST) begin : g_fixed
                assign cell_expect[k] = FRAME_PAT[k];
            end else begin : g_tag
                assign cell_expect[k] = r_tag[8*(k-TAG_FIRST) +: 8];
            end

            if (k == CHAIN_LEN - 1) begin : g_top
                cfd_cell u_cell (
                    .i_clk    (i_clk),
                    .i_shift  (in_xfer),
                    .i_byte   (i_data_byte),
                    .i_expect (cell_expect[k]),
                    .o_byte   (cell_byte[k]),
                    .o_hit    (cell_hit[k])
                );
            end else begin : g_mid
                cfd_cell u_cell (
                    .i_clk    (i_clk),
                    .i_shift  (in_xfer),
                    .i_byte   (cell_byte[k+1]),
                    .i_expect (cell_expect[k]),
                    .o_byte   (cell_byte[k]),
                    .o_hit    (cell_hit[k])
                );
            end
        end
    endgenerate

    // Every fixed and tag position must hit; the opcode cell is skipped and the
    // arriving byte supplies the top tag byte.
    always_comb begin
        frame_hit = (i_data_byte == r_tag[31:24]);
        for (int j = 0; j < CHAIN_LEN; j++) begin
            if (j != OPCODE_POS) begin
                frame_hit = frame_hit & cell_hit[j];
            end
        end
    end

    always_comb begin
        case (cell_byte[OPCODE_POS])
            OP_START:  decoded = EVT_START;
            OP_STOP:   decoded = EVT_STOP;
            OP_QUERY:  decoded = EVT_QUERY;
            OP_PROMPT: decoded = r_prompt_en ? EVT_PROMPT : EVT_NONE;
            default:   decoded = EVT_NONE;
        endcase
    end

    // Fill count and event for this transfer
    always_comb begin
        n_fill  = r_fill;
        n_event = r_event;
        if (in_xfer) begin
            n_event = EVT_NONE;
            if (i_line_error != 4'd0) begin
                n_fill = '0;
            end else if (r_fill == FILL_W'(CHAIN_LEN)) begin
                if (frame_hit && decoded != EVT_NONE) begin
                    n_event = decoded;
                    n_fill  = '0;
                end
                // A miss slides the window: the count holds at fifteen.
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_xfer) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_event <= n_event;
    end

    assign o_out_valid     = r_out_valid;
    assign o_command_event = r_event;

    // A reported command always leaves the window empty.
    a_event_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_event != EVT_NONE) |-> (r_fill == '0))
        else $error("command event with non-empty window");

    // An error entry empties the window and reports nothing.
    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_line_error != 4'd0) |=> (r_fill == '0 && r_event == EVT_NONE))
        else $error("error entry did not clear the window");

    // Every taken byte has its result waiting in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_out_valid)
        else $error("transfer without a result");

    // No event can come before the window has been filled.
    a_no_early_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_fill != FILL_W'(CHAIN_LEN)) |=> (r_event == EVT_NONE))
        else $error("event from a partial window");

endmodule
